/* rtl/esto_pkg.sv */
// ----------------------------------------------------------------------------
// esto_pkg
// Shared sizes and controller/datapath command and status types for the
// exit status table with oldest-entry replacement.
// ----------------------------------------------------------------------------
`default_nettype none

package esto_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);

   // field widths
   localparam int PID_W    = 31;
   localparam int STATUS_W = 32;
   localparam int TIME_W   = 32;

   // request kinds
   localparam logic REQ_RECORD = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // result codes
   localparam logic RES_OK       = 1'b0;
   localparam logic RES_NOTFOUND = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic query;
      logic scan_step;
      logic evict;
      logic insert;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_query;
      logic full;
      logic scan_last;
      logic rsp_busy;
   } stat_type;

endpackage

`default_nettype wire

/* rtl/esto_ctrl.sv */
// ----------------------------------------------------------------------------
// esto_ctrl
// Sequencer: lookup, oldest-entry scan when full, evict, insert and
// hand-off of the result beat to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module esto_ctrl
   import esto_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOOKUP = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_EVICT  = 6'b001000,
      ST_INSERT = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // only take a beat when idle
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (stat.is_query) begin
               cmd.query = 1'b1;
               state_in  = ST_RESP;
            end else if (stat.full) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            cmd.evict = 1'b1;
            state_in  = ST_INSERT;
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/esto_dp.sv */
// ----------------------------------------------------------------------------
// esto_dp
// Table storage, parallel key match, free-slot pick, one-entry-per-cycle
// oldest scan, result register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module esto_dp
   import esto_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_req_type,
   input  wire logic [PID_W-1:0]           req_pid,
   input  wire logic signed [STATUS_W-1:0] req_exit_status,
   input  wire logic [TIME_W-1:0]          req_timestamp,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_result_code,
   output logic signed [STATUS_W-1:0]      rsp_status_out,
   output logic                            rsp_evicted,
   input  wire cmd_type                    cmd,
   output stat_type                        stat
);

   // captured request
   logic                       req_type_ff;
   logic [PID_W-1:0]           key_ff;
   logic signed [STATUS_W-1:0] new_status_ff;
   logic [TIME_W-1:0]          new_time_ff;

   // table
   logic [TABLE_DEPTH-1:0]     valid_ff;
   logic [PID_W-1:0]           pid_ff    [TABLE_DEPTH];
   logic [TIME_W-1:0]          time_ff   [TABLE_DEPTH];
   logic signed [STATUS_W-1:0] status_ff [TABLE_DEPTH];

   // oldest scan
   logic [IDX_W-1:0]           scan_idx_ff;
   logic [IDX_W-1:0]           best_idx_ff;
   logic [TIME_W-1:0]          best_time_ff;
   logic [PID_W-1:0]           best_pid_ff;

   // pending result
   logic                       res_code_ff;
   logic signed [STATUS_W-1:0] res_status_ff;
   logic                       res_evicted_ff;

   // output register
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       rsp_code_ff;
   logic signed [STATUS_W-1:0] rsp_status_ff;
   logic                       rsp_evicted_ff;

   logic [TABLE_DEPTH-1:0]     match;
   logic                       hit;
   logic [IDX_W-1:0]           hit_idx;
   logic                       full;
   logic [IDX_W-1:0]           free_idx;
   logic [TIME_W-1:0]          cur_time;
   logic [PID_W-1:0]           cur_pid;
   logic                       older;

   // key match and lowest free slot
   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         match[i] = valid_ff[i] && (pid_ff[i] == key_ff);
         if (match[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign hit  = |match;
   assign full = &valid_ff;

   // oldest compare: least time, then smaller pid
   assign cur_time = time_ff[scan_idx_ff];
   assign cur_pid  = pid_ff[scan_idx_ff];
   assign older    = (scan_idx_ff == '0) || (cur_time < best_time_ff) ||
                     ((cur_time == best_time_ff) && (cur_pid < best_pid_ff));

   // status to controller
   assign stat.is_query  = (req_type_ff == REQ_QUERY);
   assign stat.full      = full;
   assign stat.scan_last = (scan_idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign stat.rsp_busy  = rsp_valid_ff && rsp_stall;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_type_ff   <= req_req_type;
         key_ff        <= req_pid;
         new_status_ff <= req_exit_status;
         new_time_ff   <= req_timestamp;
      end
   end

   // entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (cmd.query && hit) begin
            valid_ff[hit_idx] <= 1'b0;
         end else if (cmd.evict) begin
            valid_ff[best_idx_ff] <= 1'b0;
         end else if (cmd.insert && !hit && !full) begin
            valid_ff[free_idx] <= 1'b1;
         end
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      if (cmd.insert && !hit && !full) begin
         pid_ff[free_idx]    <= key_ff;
         time_ff[free_idx]   <= new_time_ff;
         status_ff[free_idx] <= new_status_ff;
      end
   end

   // scan counter and best candidate
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
      end else if (cmd.load_req) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && older) begin
         best_idx_ff  <= scan_idx_ff;
         best_time_ff <= cur_time;
         best_pid_ff  <= cur_pid;
      end
   end

   // result build-up
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         res_code_ff    <= RES_OK;
         res_status_ff  <= '0;
         res_evicted_ff <= 1'b0;
      end else if (cmd.query) begin
         if (hit) begin
            res_status_ff <= status_ff[hit_idx];
         end else begin
            res_code_ff <= RES_NOTFOUND;
         end
      end else if (cmd.evict) begin
         res_evicted_ff <= 1'b1;
      end
   end

   // output register
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_code_ff    <= res_code_ff;
         rsp_status_ff  <= res_status_ff;
         rsp_evicted_ff <= res_evicted_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_code = rsp_code_ff;
   assign rsp_status_out  = rsp_status_ff;
   assign rsp_evicted     = rsp_evicted_ff;

endmodule

`default_nettype wire

/* rtl/exit_status_table_oldest_evict_core.sv */
// Path, accept to rsp_valid: a query passes LOOKUP and RESP, a record into a
// table with a free slot LOOKUP, INSERT and RESP, and a record into a full table
// LOOKUP, SCAN over every entry, EVICT, INSERT and RESP. One item at a time; the
// full-table path is set by the oldest-entry scan, which reads one table entry per cycle.
// The next beat is taken while a result still waits in the output register.
// Synchronous reset empties the table (valid bits only) and idles the sequencer.
`default_nettype none

// ----------------------------------------------------------------------------
// exit_status_table_oldest_evict_core
// Exit status table keyed by pid: record with oldest-entry replacement when
// full, query with removal on hit.
// ----------------------------------------------------------------------------
module exit_status_table_oldest_evict_core
   import esto_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_req_type,
   input  wire logic [PID_W-1:0]           req_pid,
   input  wire logic signed [STATUS_W-1:0] req_exit_status,
   input  wire logic [TIME_W-1:0]          req_timestamp,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_result_code,
   output logic signed [STATUS_W-1:0]      rsp_status_out,
   output logic                            rsp_evicted
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   esto_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table and result path
   esto_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_req_type    (req_req_type),
      .req_pid         (req_pid),
      .req_exit_status (req_exit_status),
      .req_timestamp   (req_timestamp),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_code (rsp_result_code),
      .rsp_status_out  (rsp_status_out),
      .rsp_evicted     (rsp_evicted),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

`default_nettype wire

/* rtl/esto_chk.sv */
// ----------------------------------------------------------------------------
// esto_chk
// Port-level checks for the exit status table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module esto_chk
   import esto_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic                       rsp_result_code,
   input wire logic signed [STATUS_W-1:0] rsp_status_out,
   input wire logic                       rsp_evicted
);

   // a stalled result beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_code) &&
                                 $stable(rsp_status_out) && $stable(rsp_evicted))
      else $error("stalled result beat changed");

   // one item at a time: busy right after a beat is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // a miss carries no status and no eviction
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_code == RES_NOTFOUND) |->
         (rsp_status_out == '0) && !rsp_evicted)
      else $error("not-found result with status or eviction");

   // an eviction only comes with a successful record
   a_evict_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> (rsp_result_code == RES_OK) && (rsp_status_out == '0))
      else $error("eviction flag on a non-record result");

endmodule

bind exit_status_table_oldest_evict_core esto_chk u_esto_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_code (rsp_result_code),
   .rsp_status_out  (rsp_status_out),
   .rsp_evicted     (rsp_evicted)
);

`default_nettype wire

/* dv/tb_exit_status_table_oldest_evict_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_exit_status_table_oldest_evict_core
// Self-checking bench for the exit status table. A behavioral copy of the
// table predicts every response beat; directed tests cover field extremes,
// duplicate pids and oldest-entry eviction with timestamp ties, then random
// record/query traffic over a reused pid set runs with random idles on both
// sides, a stretch with no idles and a long response hold-off.
// ----------------------------------------------------------------------------
module tb_exit_status_table_oldest_evict_core;
   import esto_pkg::*;

   localparam int POOL_SIZE = 24;

   typedef struct {
      logic                       code;
      logic signed [STATUS_W-1:0] status;
      logic                       evicted;
   } table_result_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_req_type;
   logic [PID_W-1:0]           req_pid;
   logic signed [STATUS_W-1:0] req_exit_status;
   logic [TIME_W-1:0]          req_timestamp;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_result_code;
   logic signed [STATUS_W-1:0] rsp_status_out;
   logic                       rsp_evicted;

   // predicted table contents
   logic                       tbl_valid  [TABLE_DEPTH];
   logic [PID_W-1:0]           tbl_pid    [TABLE_DEPTH];
   logic [TIME_W-1:0]          tbl_time   [TABLE_DEPTH];
   logic signed [STATUS_W-1:0] tbl_status [TABLE_DEPTH];

   table_result_type pending_results[$];
   table_result_type head;
   logic [PID_W-1:0] pid_pool [POOL_SIZE];
   logic [TIME_W-1:0] wall_seconds;

   bit no_idle   = 1'b0;
   int hold_left = 0;
   int mismatch_count = 0;
   int n_records = 0;
   int n_queries = 0;
   int n_hits = 0;
   int n_evictions = 0;

   exit_status_table_oldest_evict_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_req_type    (req_req_type),
      .req_pid         (req_pid),
      .req_exit_status (req_exit_status),
      .req_timestamp   (req_timestamp),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_code (rsp_result_code),
      .rsp_status_out  (rsp_status_out),
      .rsp_evicted     (rsp_evicted)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("timeout with %0d responses outstanding", pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // lowest free slot, -1 when full
   function automatic int free_slot();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (!tbl_valid[i]) return i;
      end
      return -1;
   endfunction

   // slot holding a pid, -1 when absent
   function automatic int key_slot(logic [PID_W-1:0] key);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (tbl_valid[i] && tbl_pid[i] == key) return i;
      end
      return -1;
   endfunction

   // update the predicted table with one request and return its response
   function automatic table_result_type apply_request(logic kind, logic [PID_W-1:0] key,
                                                      logic signed [STATUS_W-1:0] st,
                                                      logic [TIME_W-1:0] ts);
      table_result_type r;
      int slot;
      int best;
      r.code = RES_OK;
      r.status = '0;
      r.evicted = 1'b0;
      if (kind == REQ_RECORD) begin
         // full table: drop least timestamp, smaller pid on ties
         if (free_slot() < 0) begin
            best = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (tbl_valid[i] && (best < 0 || tbl_time[i] < tbl_time[best] ||
                   (tbl_time[i] == tbl_time[best] && tbl_pid[i] < tbl_pid[best])))
                  best = i;
            end
            if (best >= 0) begin
               tbl_valid[best] = 1'b0;
               r.evicted = 1'b1;
            end
         end
         // insert only when the pid is not held already
         if (key_slot(key) < 0) begin
            slot = free_slot();
            if (slot >= 0) begin
               tbl_valid[slot]  = 1'b1;
               tbl_pid[slot]    = key;
               tbl_time[slot]   = ts;
               tbl_status[slot] = st;
            end
         end
      end else begin
         slot = key_slot(key);
         if (slot >= 0) begin
            r.status = tbl_status[slot];
            tbl_valid[slot] = 1'b0;
         end else begin
            r.code = RES_NOTFOUND;
         end
      end
      return r;
   endfunction

   // offer one request beat, predict its response once accepted
   task automatic send_beat(logic kind, logic [PID_W-1:0] key,
                            logic signed [STATUS_W-1:0] st, logic [TIME_W-1:0] ts);
      table_result_type r;
      while (!no_idle && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_req_type    <= kind;
      req_pid         <= key;
      req_exit_status <= st;
      req_timestamp   <= ts;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = apply_request(kind, key, st, ts);
      pending_results.push_back(r);
      if (kind == REQ_RECORD) begin
         n_records++;
         if (r.evicted) n_evictions++;
      end else begin
         n_queries++;
         if (r.code == RES_OK) n_hits++;
      end
   endtask

   // response stall: random idles plus requested hold-off
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!no_idle && $urandom_range(99) < 18) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response beat at %0t", $time);
         end else begin
            head = pending_results.pop_front();
            if (rsp_result_code !== head.code || rsp_status_out !== head.status ||
                rsp_evicted !== head.evicted) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at %0t: expected code=%0d status=%0d evicted=%0d,",
                           $time, head.code, head.status, head.evicted,
                           " got code=%0d status=%0d evicted=%0d",
                           rsp_result_code, rsp_status_out, rsp_evicted);
            end
         end
      end
   end

   // extreme pids, statuses and timestamps, hit then miss, duplicate on a non-full table
   task automatic test_extremes();
      send_beat(REQ_RECORD, '0, 32'sh8000_0000, 32'h0000_0000);
      send_beat(REQ_QUERY, '0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      send_beat(REQ_QUERY, '0, 32'sh0, 32'h0);
      send_beat(REQ_RECORD, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      send_beat(REQ_RECORD, 31'h7FFF_FFFF, 32'sh1, 32'h0000_0001);
   endtask

   // fill the table, then evict with a timestamp tie and with pids already present
   task automatic test_fill_and_evict();
      for (int i = 1; i <= 15; i++)
         send_beat(REQ_RECORD, PID_W'(i), STATUS_W'(-i),
                   (i == 2 || i == 3) ? 32'd5 : TIME_W'(100 + i));
      send_beat(REQ_RECORD, 31'd200, 32'sd200, 32'd400);
      // pid 3 is now the oldest: evicted and rewritten
      send_beat(REQ_RECORD, 31'd3, 32'sd333, 32'd500);
      // held pid that is not the oldest: eviction, insert dropped
      send_beat(REQ_RECORD, 31'h7FFF_FFFF, 32'sd7, 32'd600);
      send_beat(REQ_QUERY, 31'h7FFF_FFFF, 32'sd0, 32'd0);
      send_beat(REQ_QUERY, 31'd3, 32'sd0, 32'd0);
   endtask

   // random records and queries, mostly over a reused pid set
   task automatic test_random_traffic(int n_items);
      logic kind;
      logic [PID_W-1:0] key;
      logic [TIME_W-1:0] ts;
      for (int k = 0; k < n_items; k++) begin
         kind = ($urandom_range(99) < 58) ? REQ_RECORD : REQ_QUERY;
         if ($urandom_range(99) < 85) key = pid_pool[$urandom_range(POOL_SIZE - 1)];
         else key = PID_W'($urandom);
         // slowly advancing time so that ties are common
         wall_seconds += $urandom_range(3);
         ts = ($urandom_range(99) < 5) ? $urandom : wall_seconds;
         send_beat(kind, key, $urandom, ts);
      end
   endtask

   // long response hold-off while requests keep coming
   task automatic test_backpressure();
      hold_left = 300;
      test_random_traffic(40);
   endtask

   // main sequence
   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_req_type    <= REQ_RECORD;
      req_pid         <= '0;
      req_exit_status <= '0;
      req_timestamp   <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
      for (int i = 0; i < POOL_SIZE; i++)
         pid_pool[i] = (i < POOL_SIZE / 2) ? PID_W'($urandom_range(40)) : PID_W'($urandom);
      wall_seconds = $urandom;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_extremes();
      test_fill_and_evict();
      test_random_traffic(800);
      no_idle = 1'b1;
      test_random_traffic(400);
      test_backpressure();
      no_idle = 1'b0;
      test_random_traffic(550);

      // drain
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);

      $display("covered %0d records (%0d with eviction) and %0d queries (%0d hits)",
               n_records, n_evictions, n_queries, n_hits);
      $display("with random idles, an idle-free stretch and a 300-cycle response hold-off");
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
